// ===== rtl/sams_pkg.sv =====
// ----------------------------------------------------------------------------
// sams_pkg
// Shared types and constants for the multi-stack block.
// ----------------------------------------------------------------------------
package sams_pkg;

  localparam int DEPTH      = 64;
  localparam int MAX_STACKS = 8;
  localparam int WORD_BITS  = 32;

  localparam int ADDR_W = $clog2(DEPTH);
  localparam int PTR_W  = ADDR_W + 1;
  localparam int SID_W  = $clog2(MAX_STACKS);
  localparam int CNT_W  = SID_W + 1;

  typedef enum logic [1:0] {
    OP_PUSH    = 2'd0,
    OP_POP     = 2'd1,
    OP_DISPLAY = 2'd2,
    OP_LAYOUT  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_BAD_ID = 2'd3
  } status_t;

  localparam logic CFG_TOTAL_SIZE  = 1'b0;
  localparam logic CFG_STACK_COUNT = 1'b1;

  typedef struct packed {
    op_t                   op;
    logic [2:0]            id;
    logic [WORD_BITS-1:0]  val;
  } req_t;

  typedef enum logic [3:0] {
    S_CLAMP, S_DIV, S_LAY, S_IDLE, S_DEC, S_NXCHK, S_SH_RD, S_SH_WR,
    S_FIX, S_PUSH, S_POP, S_DISP_RD, S_DISP_OUT, S_RESP
  } state_t;

endpackage

// ===== rtl/sams_queue.sv =====
// ----------------------------------------------------------------------------
// sams_queue
// Two-entry request queue between the input port and the execution engine.
// ----------------------------------------------------------------------------
module sams_queue import sams_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  req_t in_req,
  output logic q_valid,
  input  logic q_pop,
  output req_t q_req
);

  req_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign in_ready = (count != 2'd2);
  assign q_valid  = (count != 2'd0);
  assign q_req    = slots[rd_ptr];
  assign push     = in_valid && in_ready;
  assign pop      = q_pop && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_req;
    end
  end

  a_count_max: assert property (@(posedge clk) disable iff (rst) count <= 2'd2)
    else $error("queue count overflow");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    (count == 2'd0) |-> !pop) else $error("pop from empty queue");
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + 2'd1)) else $error("count step");

endmodule

// ===== rtl/sams_engine.sv =====
// ----------------------------------------------------------------------------
// sams_engine
// Executes requests against the stack tables and the shared slot memory.
// ----------------------------------------------------------------------------
module sams_engine import sams_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_valid,
  input  req_t                 q_req,
  output logic                 q_pop,
  input  logic                 cfg_valid,
  input  logic                 cfg_index,
  input  logic [6:0]           cfg_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           status,
  output logic [31:0]          data_word,
  output logic                 last
);

  state_t state;
  state_t state_next;

  logic [6:0] cfg_total;
  logic [3:0] cfg_count;

  logic [PTR_W-1:0] base [MAX_STACKS];
  logic [PTR_W-1:0] ptr  [MAX_STACKS];
  logic [PTR_W-1:0] lim1 [MAX_STACKS];
  logic [CNT_W-1:0] live;

  logic [WORD_BITS-1:0] mem [DEPTH];
  logic [WORD_BITS-1:0] rdata;
  logic                 mem_we;
  logic [ADDR_W-1:0]    mem_wa;
  logic [WORD_BITS-1:0] mem_wd;
  logic                 mem_re;
  logic [ADDR_W-1:0]    mem_ra;

  op_t                  op;
  logic [2:0]           id;
  logic [WORD_BITS-1:0] val;
  logic [PTR_W-1:0]     cp, cl, nb, np;
  logic [PTR_W-1:0]     idx;
  logic [6:0]           t_r;
  logic [CNT_W-1:0]     s_r;
  logic [6:0]           rem;
  logic [6:0]           per;
  logic [7:0]           acc;
  logic [SID_W-1:0]     lay_i;
  logic                 lay_resp;
  status_t              rsp_status;
  logic [31:0]          rsp_data;

  logic [SID_W-1:0] tsel;
  logic [PTR_W-1:0] rb, rp, rl;
  logic             out_free;
  logic             bad_id;
  logic             no_next;
  logic             disp_last;
  logic [6:0]       t_clamp;
  logic [CNT_W-1:0] s_clamp;

  assign tsel      = (state == S_NXCHK) ? SID_W'(id + 3'd1) : SID_W'(id);
  assign rb        = base[tsel];
  assign rp        = ptr[tsel];
  assign rl        = lim1[tsel];
  assign out_free  = !out_valid || out_ready;
  assign bad_id    = ({1'b0, id} >= live);
  assign no_next   = (({1'b0, id} + 4'd1) >= live);
  assign disp_last = ((idx + 7'd1) == cp);

  always_comb begin
    t_clamp = cfg_total;
    if (cfg_total < 7'd4) t_clamp = 7'd4;
    if (cfg_total > 7'(DEPTH)) t_clamp = 7'(DEPTH);
    s_clamp = cfg_count;
    if (cfg_count < 4'd3) s_clamp = 4'd3;
    if (cfg_count > 4'(MAX_STACKS)) s_clamp = 4'(MAX_STACKS);
    if ({3'b0, s_clamp} >= t_clamp) s_clamp = CNT_W'(t_clamp - 7'd1);
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLAMP: state_next = S_DIV;
      S_DIV:   if (rem < {3'b0, s_r}) state_next = S_LAY;
      S_LAY: begin
        if (lay_i == SID_W'(MAX_STACKS - 1)) state_next = lay_resp ? S_RESP : S_IDLE;
      end
      S_IDLE: if (q_valid) state_next = S_DEC;
      S_DEC: begin
        priority if (op == OP_LAYOUT) state_next = S_CLAMP;
        else if (bad_id) state_next = S_RESP;
        else if (op == OP_PUSH) begin
          priority if (rp < rl) state_next = S_PUSH;
          else if (no_next) state_next = S_RESP;
          else state_next = S_NXCHK;
        end
        else if (rp == rb) state_next = S_RESP;
        else if (op == OP_POP) state_next = S_POP;
        else state_next = S_DISP_RD;
      end
      S_NXCHK: begin
        priority if (rp >= rl) state_next = S_RESP;
        else if (rp == rb) state_next = S_FIX;
        else state_next = S_SH_RD;
      end
      S_SH_RD:  state_next = S_SH_WR;
      S_SH_WR:  state_next = (idx == nb) ? S_FIX : S_SH_RD;
      S_FIX:    state_next = S_PUSH;
      S_PUSH:   state_next = S_RESP;
      S_POP:    state_next = S_RESP;
      S_RESP:   if (out_free) state_next = S_IDLE;
      S_DISP_RD: state_next = S_DISP_OUT;
      S_DISP_OUT: if (out_free) state_next = disp_last ? S_IDLE : S_DISP_RD;
      default:  state_next = S_IDLE;
    endcase
  end

  // strobes
  always_comb begin
    q_pop  = 1'b0;
    mem_we = 1'b0;
    mem_wa = ADDR_W'(idx + 7'd1);
    mem_wd = rdata;
    mem_re = 1'b0;
    mem_ra = ADDR_W'(idx);
    unique case (state)
      S_IDLE: q_pop = q_valid;
      S_DEC: begin
        mem_re = 1'b1;
        mem_ra = ADDR_W'(rp - 7'd1);
      end
      S_SH_RD, S_DISP_RD: mem_re = 1'b1;
      S_SH_WR: mem_we = 1'b1;
      S_PUSH: begin
        mem_we = 1'b1;
        mem_wa = ADDR_W'(cp);
        mem_wd = val;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (mem_re) rdata <= mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLAMP;
      cfg_total <= 7'd64;
      cfg_count <= 4'd4;
      lay_resp  <= 1'b0;
      out_valid <= 1'b0;
      live      <= 4'd4;
    end else begin
      state <= state_next;
      if (cfg_valid) begin
        if (cfg_index == CFG_TOTAL_SIZE) cfg_total <= cfg_data;
        if (cfg_index == CFG_STACK_COUNT) cfg_count <= cfg_data[3:0];
      end
      if (out_valid && out_ready) out_valid <= 1'b0;
      if ((state == S_RESP || state == S_DISP_OUT) && out_free) out_valid <= 1'b1;
      if (state == S_LAY && lay_i == SID_W'(MAX_STACKS - 1)) live <= s_r;
      if (state == S_DEC && op == OP_LAYOUT) lay_resp <= 1'b1;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state)
      S_CLAMP: begin
        t_r   <= t_clamp;
        s_r   <= s_clamp;
        rem   <= t_clamp;
        per   <= 7'd0;
        acc   <= 8'd0;
        lay_i <= '0;
      end
      S_DIV: begin
        if (rem >= {3'b0, s_r}) begin
          rem <= rem - {3'b0, s_r};
          per <= per + 7'd1;
        end
      end
      S_LAY: begin
        base[lay_i] <= ({1'b0, lay_i} < s_r) ? PTR_W'(acc) : t_r;
        ptr[lay_i]  <= ({1'b0, lay_i} < s_r) ? PTR_W'(acc) : t_r;
        lim1[lay_i] <= (({1'b0, lay_i} + 4'd1) < s_r) ? PTR_W'(acc + {1'b0, per}) : t_r;
        acc         <= acc + {1'b0, per};
        lay_i       <= lay_i + 1'b1;
        rsp_status  <= ST_OK;
        rsp_data    <= '0;
      end
      S_IDLE: begin
        op  <= q_req.op;
        id  <= q_req.id;
        val <= q_req.val;
      end
      S_DEC: begin
        cp <= rp;
        cl <= rl;
        rsp_data <= '0;
        priority if (bad_id) rsp_status <= ST_BAD_ID;
        else if (op == OP_PUSH) rsp_status <= ST_FULL;
        else rsp_status <= ST_EMPTY;
        idx <= rb;
      end
      S_NXCHK: begin
        nb  <= rb;
        np  <= rp;
        idx <= rp - 7'd1;
      end
      S_SH_WR: idx <= idx - 7'd1;
      S_FIX: begin
        base[SID_W'(id + 3'd1)] <= nb + 7'd1;
        ptr[SID_W'(id + 3'd1)]  <= np + 7'd1;
        lim1[SID_W'(id)]        <= cl + 7'd1;
      end
      S_PUSH: begin
        ptr[SID_W'(id)] <= cp + 7'd1;
        rsp_status      <= ST_OK;
      end
      S_POP: begin
        ptr[SID_W'(id)] <= cp - 7'd1;
        rsp_status      <= ST_OK;
        rsp_data        <= 32'(signed'(rdata));
      end
      S_DISP_OUT: if (out_free) idx <= idx + 7'd1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == S_RESP && out_free) begin
      status    <= rsp_status;
      data_word <= rsp_data;
      last      <= 1'b1;
    end else if (state == S_DISP_OUT && out_free) begin
      status    <= ST_OK;
      data_word <= 32'(signed'(rdata));
      last      <= disp_last;
    end
  end

  a_live_range: assert property (@(posedge clk) disable iff (rst)
    (live >= 4'd3) && (live <= 4'(MAX_STACKS))) else $error("live count out of range");
  a_shift_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_SH_WR) |-> (idx >= nb)) else $error("shift below next base");
  a_push_in_room: assert property (@(posedge clk) disable iff (rst)
    (state == S_PUSH) |-> (cp < DEPTH)) else $error("push address out of range");

endmodule

// ===== rtl/shared_array_multi_stack.sv =====
// ----------------------------------------------------------------------------
// shared_array_multi_stack
// Up to eight stacks sharing one 64-word memory, with borrow on full.
// ----------------------------------------------------------------------------
// Requests enter a two-entry queue and are executed one at a time by the
// engine. A push that borrows a slot first moves every entry of the next stack
// up by one, each read from memory and then written back. Display emits one
// result per word, each word read before it is output. A layout (opcode 3)
// runs a subtract-loop divider and a one-stack-per-cycle table sweep; the same
// divide and sweep run after reset, during which no request is taken from the
// queue. A stalled output holds the engine in its response and display states.
// Configuration writes are taken at any time and apply at the next layout.
module shared_array_multi_stack import sams_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  opcode,
  input  logic [2:0]  stack_id,
  input  logic [31:0] push_value,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [6:0]  cfg_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [31:0] data_word,
  output logic        last
);

  req_t in_req;
  req_t q_req;
  logic q_valid;
  logic q_pop;

  // front: accept and hold requests
  assign in_req.op  = op_t'(opcode);
  assign in_req.id  = stack_id;
  assign in_req.val = push_value;
  assign cfg_ready  = 1'b1;

  sams_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_req   (in_req),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_req    (q_req)
  );

  // back: execute against tables and memory
  sams_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_req     (q_req),
    .q_pop     (q_pop),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .data_word (data_word),
    .last      (last)
  );

endmodule

// ===== verif/tb_shared_array_multi_stack.sv =====
// ----------------------------------------------------------------------------
// tb_shared_array_multi_stack
// Drives push, pop, display and layout requests into the shared-array stack
// block, predicts every result with a local model of the stack tables and the
// word store, and checks the results in order.
// ----------------------------------------------------------------------------

// Scoreboard: holds its own copy of the stack tables and predicts per request.
class stack_scoreboard;
  logic [31:0] words[64];
  int          base_ptr[8];
  int          top_ptr[8];
  int          limit_ptr[8];
  int          live_cnt;
  logic [6:0]  size_reg;
  logic [3:0]  count_reg;
  logic [1:0]  exp_status[$];
  logic [31:0] exp_word[$];
  logic        exp_last[$];
  int          mismatches;

  function new();
    foreach (words[i]) words[i] = '0;
    size_reg   = 7'd64;
    count_reg  = 4'd4;
    mismatches = 0;
    relayout();
  endfunction

  function void relayout();
    int t, s, per;
    t = size_reg;
    s = count_reg;
    if (t < 4) t = 4;
    if (t > 64) t = 64;
    if (s < 3) s = 3;
    if (s > 8) s = 8;
    if (s >= t) s = t - 1;
    per = t / s;
    live_cnt = s;
    for (int i = 0; i < 8; i++) begin
      base_ptr[i]  = (i < s) ? i * per : t;
      top_ptr[i]   = base_ptr[i] - 1;
      limit_ptr[i] = (i < s - 1) ? (i + 1) * per - 1 : t - 1;
    end
  endfunction

  function void write_reg(logic idx, logic [6:0] data);
    if (idx == sams_pkg::CFG_TOTAL_SIZE) size_reg = data;
    else count_reg = data[3:0];
  endfunction

  function void push_exp(logic [1:0] st, logic [31:0] w, logic l);
    exp_status.push_back(st);
    exp_word.push_back(w);
    exp_last.push_back(l);
  endfunction

  function logic [1:0] do_push(int id, logic [31:0] v);
    int nx;
    if (top_ptr[id] >= limit_ptr[id]) begin
      nx = id + 1;
      if (nx >= live_cnt || top_ptr[nx] >= limit_ptr[nx]) return sams_pkg::ST_FULL;
      for (int j = top_ptr[nx]; j >= base_ptr[nx]; j--) words[(j + 1) % 64] = words[j % 64];
      base_ptr[nx]++;
      top_ptr[nx]++;
      limit_ptr[id]++;
    end
    top_ptr[id]++;
    words[top_ptr[id] % 64] = v;
    return sams_pkg::ST_OK;
  endfunction

  // Note one accepted request and queue its expected results.
  function void note_request(logic [1:0] op, logic [2:0] id, logic [31:0] v);
    if (op == sams_pkg::OP_LAYOUT) begin
      relayout();
      push_exp(sams_pkg::ST_OK, '0, 1'b1);
    end else if (id >= live_cnt) begin
      push_exp(sams_pkg::ST_BAD_ID, '0, 1'b1);
    end else if (op == sams_pkg::OP_PUSH) begin
      push_exp(do_push(id, v), '0, 1'b1);
    end else if (top_ptr[id] < base_ptr[id]) begin
      push_exp(sams_pkg::ST_EMPTY, '0, 1'b1);
    end else if (op == sams_pkg::OP_POP) begin
      push_exp(sams_pkg::ST_OK, words[top_ptr[id] % 64], 1'b1);
      top_ptr[id]--;
    end else begin
      for (int i = base_ptr[id]; i <= top_ptr[id]; i++)
        push_exp(sams_pkg::ST_OK, words[i % 64], i == top_ptr[id]);
    end
  endfunction

  // Compare one result with the oldest expectation.
  function void check_result(logic [1:0] st, logic [31:0] w, logic l);
    if (exp_status.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result status=%0d word=%h last=%0d", st, w, l);
      return;
    end
    if (st !== exp_status[0] || w !== exp_word[0] || l !== exp_last[0]) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: exp status=%0d word=%h last=%0d, got status=%0d word=%h last=%0d",
                 exp_status[0], exp_word[0], exp_last[0], st, w, l);
    end
    void'(exp_status.pop_front());
    void'(exp_word.pop_front());
    void'(exp_last.pop_front());
  endfunction

  function int pending();
    return exp_status.size();
  endfunction
endclass

module tb_shared_array_multi_stack;
  import sams_pkg::*;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  opcode;
  logic [2:0]  stack_id;
  logic [31:0] push_value;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [6:0]  cfg_data;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  status;
  logic [31:0] data_word;
  logic        last;

  stack_scoreboard sb;
  bit  sink_hold;      // receiver holds off completely while set
  bit  calm_sink;      // no random stalls while set
  int  sender_idle_pct;

  shared_array_multi_stack u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .opcode(opcode), .stack_id(stack_id), .push_value(push_value),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .data_word(data_word), .last(last)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #4000000;
    $display("tb_shared_array_multi_stack: FAIL");
    $finish;
  end

  // Receiver: random stalls, sample results at the edge.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) sb.check_result(status, data_word, last);
      if (sink_hold) out_ready <= 1'b0;
      else if (calm_sink) out_ready <= 1'b1;
      else out_ready <= ($urandom_range(99) >= 30);
    end
  end

  // Offer one request; random idle cycles ahead, hold until accepted.
  // Valid stays high after acceptance so back-to-back requests need no gap;
  // drain drops it when the sender goes quiet.
  task automatic send_request(logic [1:0] op, logic [2:0] id, logic [31:0] v);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    opcode     <= op;
    stack_id   <= id;
    push_value <= v;
    do @(posedge clk); while (!in_ready);
    sb.note_request(op, id, v);
  endtask

  // Let every expected result arrive, then pad for work that gives no result.
  task automatic drain();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    while (sb.pending() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (150) @(posedge clk);
  endtask

  task automatic write_cfg(logic idx, logic [6:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
  endtask

  // Push-heavy random mix on live stacks, with some bad ids, displays and layouts.
  task automatic random_request();
    int r;
    logic [2:0] id;
    r  = $urandom_range(99);
    id = ($urandom_range(9) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(sb.live_cnt - 1));
    if (r < 50) send_request(OP_PUSH, id, $urandom);
    else if (r < 80) send_request(OP_POP, id, $urandom);
    else if (r < 97) send_request(OP_DISPLAY, id, $urandom);
    else send_request(OP_LAYOUT, id, $urandom);
  endtask

  task automatic config_phase(logic [6:0] sz, logic [6:0] cnt);
    drain();
    write_cfg(CFG_TOTAL_SIZE, sz);
    write_cfg(CFG_STACK_COUNT, cnt);
    cfg_valid <= 1'b0;
    send_request(OP_LAYOUT, 3'd0, '0);
  endtask

  initial begin
    sb = new();
    rst = 1'b1;
    in_valid = 1'b0; opcode = '0; stack_id = '0; push_value = '0;
    cfg_valid = 1'b0; cfg_index = 1'b0; cfg_data = '0;
    sink_hold = 1'b0; calm_sink = 1'b0; sender_idle_pct = 30;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empties, extremes of the word, borrow chain, last-stack full.
    send_request(OP_POP, 3'd0, '0);
    send_request(OP_DISPLAY, 3'd1, '0);
    send_request(OP_PUSH, 3'd7, 32'hFFFF_FFFF);
    send_request(OP_POP, 3'd5, '0);
    config_phase(7'd4, 7'd3);          // tiny: per = 1, last stack gets 2
    send_request(OP_PUSH, 3'd0, 32'h8000_0000);
    send_request(OP_PUSH, 3'd0, 32'h7FFF_FFFF);  // borrow from stack 1
    send_request(OP_PUSH, 3'd0, 32'h0000_0001);  // stack 1 has no free slot left, so this push is full
    send_request(OP_PUSH, 3'd2, 32'h1234_5678);
    send_request(OP_PUSH, 3'd2, 32'hDEAD_BEEF);
    send_request(OP_PUSH, 3'd2, 32'h0);          // last stack full
    send_request(OP_DISPLAY, 3'd0, '0);
    send_request(OP_DISPLAY, 3'd2, '0);
    send_request(OP_POP, 3'd0, '0);
    send_request(OP_POP, 3'd3, '0);              // bad id
    config_phase(7'd127, 7'd15);                 // clamped to 64, 8
    send_request(OP_PUSH, 3'd7, 32'h5555_AAAA);
    send_request(OP_DISPLAY, 3'd7, '0);
    config_phase(7'd0, 7'd0);                    // clamped to 4, 3

    // Random phases across several settings.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: config_phase(7'd12, 7'd3);
        1: config_phase(7'd64, 7'd8);
        2: config_phase(7'd9, 7'd8);             // count just below size: one slot per stack, two for the last
        3: config_phase(7'($urandom_range(4, 64)), 7'($urandom_range(3, 8)));
        4: config_phase(7'd20, 7'd5);
        default: config_phase(7'($urandom_range(127)), 7'($urandom_range(15)));
      endcase
      if (ph == 1) begin
        // No-idle stretch on both sides.
        sender_idle_pct = 0; calm_sink = 1'b1;
      end else begin
        sender_idle_pct = 30; calm_sink = 1'b0;
      end
      if (ph == 2) sink_hold = 1'b1;   // back-pressure until the queue stalls
      for (int k = 0; k < 50; k++) random_request();
      if (ph == 3) drain();            // sender waits for every result
    end

    drain();
    if (sb.mismatches == 0 && sb.pending() == 0) $display("tb_shared_array_multi_stack: PASS");
    else $display("tb_shared_array_multi_stack: FAIL");
    $finish;
  end

  // Long receiver hold-off, counted in cycles, while the sender keeps offering.
  initial begin
    wait (sink_hold);
    repeat (400) @(posedge clk);
    sink_hold = 1'b0;
  end
endmodule
